/* sv/gcsv_pkg.sv */
// Shared types, constants and the header length decode for the command
// stream verifier. No dependencies.
package gcsv_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned LEN_W  = 20;
    localparam int unsigned CNT_W  = 21;
    localparam int unsigned HLEN_W = 11;

    // client field, bits 31:29
    localparam logic [2:0] CLIENT_PARSER  = 3'd0;
    localparam logic [2:0] CLIENT_BLITTER = 3'd2;
    localparam logic [2:0] CLIENT_RENDER  = 3'd3;

    // parser opcode bits 28:23 below this are single dword
    localparam logic [5:0] PARSER_SHORT_LIMIT = 6'h09;

    // render opcode bits 28:24
    localparam logic [4:0] RND_OP_SHORT_MAX = 5'h18;
    localparam logic [4:0] RND_OP_SHORT_ALT = 5'h1C;
    localparam logic [4:0] RND_OP_BYTE_LO   = 5'h1D;
    localparam logic [4:0] RND_OP_BYTE_HI   = 5'h1E;
    localparam logic [4:0] RND_OP_WIDE      = 5'h1F;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              start;
        logic [LEN_W-1:0]  seq_len;
        logic [HLEN_W-1:0] hlen;    // decoded instruction length, 0 = invalid
    } t_cmd;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              forward;
        logic              is_header;
        logic              bad_header;
        logic [CNT_W-1:0]  count;
        logic              done;
        logic              failed;
        logic              last;
    } t_result;

    // Instruction length in dwords from a header, 0 when the header is invalid.
    function automatic logic [HLEN_W-1:0] hdr_len(input logic [WORD_W-1:0] w);
        logic [HLEN_W-1:0] n;
        n = '0;
        unique case (w[31:29])
            CLIENT_PARSER: begin
                if (w[28:23] < PARSER_SHORT_LIMIT) begin
                    n = HLEN_W'(1);
                end else begin
                    n = HLEN_W'(w[5:0]) + HLEN_W'(2);
                end
            end
            CLIENT_BLITTER: begin
                n = HLEN_W'(w[4:0]) + HLEN_W'(2);
            end
            CLIENT_RENDER: begin
                unique case (w[28:24]) inside
                    [5'h00:RND_OP_SHORT_MAX], RND_OP_SHORT_ALT: n = HLEN_W'(1);
                    RND_OP_BYTE_LO, RND_OP_BYTE_HI: n = HLEN_W'(w[7:0]) + HLEN_W'(2);
                    RND_OP_WIDE:                    n = HLEN_W'(w[9:0]) + HLEN_W'(2);
                    default:                        n = '0;
                endcase
            end
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage

/* sv/gcsv_fifo.sv */
// Small flop-based FIFO, first-word fall-through.
// Generic; no package dependency. DEPTH must be a power of two.
module gcsv_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* sv/gcsv_front.sv */
// Front end: decodes each incoming dword as a potential header and queues
// it for the back end. Depends on gcsv_pkg and gcsv_fifo.
module gcsv_front
    import gcsv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [WORD_W-1:0] i_cmd_word,
    input  logic              i_seq_start,
    input  logic [LEN_W-1:0]  i_seq_length,
    input  logic              i_pop,
    output t_cmd              o_cmd,
    output logic              o_empty
);
    t_cmd cmd_in;

    // length decode is done here so the back end only compares and counts
    always_comb begin
        cmd_in.word    = i_cmd_word;
        cmd_in.start   = i_seq_start;
        cmd_in.seq_len = i_seq_length;
        cmd_in.hlen    = hdr_len(i_cmd_word);
    end

    gcsv_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd_in),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (o_cmd),
        .o_empty (o_empty)
    );

endmodule

/* sv/gcsv_back.sv */
// Back end: sequence state, header checks, padding dword and result
// generation into the result queue. Depends on gcsv_pkg.
module gcsv_back
    import gcsv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    input  t_cmd             i_cmd,
    input  logic             i_cmd_empty,
    output logic             o_cmd_pop,
    input  logic             i_res_full,
    output logic             o_res_push,
    output t_result          o_res
);
    logic [LEN_W-1:0]  r_buffer_dwords;
    logic [CNT_W-1:0]  r_remaining, n_remaining;
    logic [HLEN_W-1:0] r_payload_left, n_payload_left;
    logic [CNT_W-1:0]  r_total, n_total;
    logic              r_error, n_error;
    logic              r_pad, n_pad;
    logic              r_pad_phase, n_pad_phase;

    logic              fire;
    logic [WORD_W-1:0] w;
    logic [HLEN_W-1:0] hlen;
    logic              hdr_ok;
    logic              from_start;

    always_comb begin
        fire      = !i_res_full && (r_pad_phase || !i_cmd_empty);
        o_cmd_pop = fire && !r_pad_phase;

        n_remaining    = r_remaining;
        n_payload_left = r_payload_left;
        n_total        = r_total;
        n_error        = r_error;
        n_pad          = r_pad;
        n_pad_phase    = 1'b0;

        from_start = !r_pad_phase && i_cmd.start;
        if (r_pad_phase) begin
            w    = '0;
            hlen = hdr_len('0);
        end else begin
            w    = i_cmd.word;
            hlen = i_cmd.hlen;
        end
        if (from_start) begin
            n_remaining    = CNT_W'(i_cmd.seq_len) + CNT_W'(i_cmd.seq_len[0]);
            n_payload_left = '0;
            n_total        = '0;
            n_error        = 1'b0;
            n_pad          = i_cmd.seq_len[0];
        end

        hdr_ok = (hlen != '0) && (CNT_W'(hlen) <= n_remaining)
                 && (LEN_W'(hlen) <= r_buffer_dwords);

        o_res            = '0;
        o_res.word       = w;
        o_res.last       = 1'b1;

        if (from_start && i_cmd.seq_len == '0) begin
            // empty sequence is rejected outright
            o_res.done   = 1'b1;
            o_res.failed = 1'b1;
        end else if (n_remaining == '0) begin
            // dword outside any sequence
            o_res.count = n_total;
        end else begin
            if (n_error) begin
                // dropped
            end else if (n_payload_left != '0) begin
                n_payload_left  = n_payload_left - HLEN_W'(1);
                n_total         = n_total + CNT_W'(1);
                o_res.forward   = 1'b1;
            end else begin
                o_res.is_header = 1'b1;
                if (hdr_ok) begin
                    n_payload_left = hlen - HLEN_W'(1);
                    n_total        = n_total + CNT_W'(1);
                    o_res.forward  = 1'b1;
                end else begin
                    n_error          = 1'b1;
                    o_res.bad_header = 1'b1;
                end
            end
            n_remaining = n_remaining - CNT_W'(1);
            o_res.count = n_total;
            if (n_remaining == '0) begin
                o_res.done   = 1'b1;
                o_res.failed = n_error;
            end
            // padding dword follows the last real dword of an odd sequence
            if (!r_pad_phase && n_pad && n_remaining == CNT_W'(1)) begin
                n_pad       = 1'b0;
                n_pad_phase = 1'b1;
                o_res.last  = 1'b0;
            end
        end

        o_res_push = fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_dwords <= '0;
            r_remaining     <= '0;
            r_payload_left  <= '0;
            r_total         <= '0;
            r_error         <= 1'b0;
            r_pad           <= 1'b0;
            r_pad_phase     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_buffer_dwords <= i_cfg_wdata;
            end
            if (fire) begin
                r_remaining    <= n_remaining;
                r_payload_left <= n_payload_left;
                r_total        <= n_total;
                r_error        <= n_error;
                r_pad          <= n_pad;
                r_pad_phase    <= n_pad_phase;
            end
        end
    end

endmodule

/* sv/gpu_command_stream_verifier.sv */
// Command stream verifier top level: front decode, command queue, back end
// checker and result queue. Depends on gcsv_pkg, gcsv_front, gcsv_back, gcsv_fifo.
//
// Accepts one command dword per clock while full is low and returns one
// result per clock while empty is low. A dword passes a 2-entry decode
// queue and a RES_DEPTH-entry (4 by default) result queue; a result can be
// popped once the back end has written it into the result queue. The back
// end makes one result a cycle while the result queue has room and it has a
// command or a padding result to make; the last dword of an odd-length
// sequence yields a second (padding) result. Header length decode happens on
// the input side; the length checks and counters live in the back end.
// buffer_dwords resets to zero, so every header fails until it is written.
module gpu_command_stream_verifier
    import gcsv_pkg::*;
#(
    parameter int unsigned RES_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [19:0]       i_cfg_wdata,
    input  logic              push,
    output logic              full,
    input  logic [31:0]       i_cmd_word,
    input  logic              i_seq_start,
    input  logic [19:0]       i_seq_length,
    output logic              empty,
    input  logic              pop,
    output logic [31:0]       o_word_out,
    output logic              o_forward,
    output logic              o_is_header,
    output logic              o_bad_header,
    output logic [20:0]       o_accepted_count,
    output logic              o_seq_done,
    output logic              o_seq_failed,
    output logic              o_run_last
);
    t_cmd    cmd;
    logic    cmd_empty, cmd_pop;
    t_result res_in, res_out;
    logic    res_full, res_push;

    gcsv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cmd_word   (i_cmd_word),
        .i_seq_start  (i_seq_start),
        .i_seq_length (i_seq_length),
        .i_pop        (cmd_pop),
        .o_cmd        (cmd),
        .o_empty      (cmd_empty)
    );

    gcsv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    gcsv_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_word_out       = res_out.word;
    assign o_forward        = res_out.forward;
    assign o_is_header      = res_out.is_header;
    assign o_bad_header     = res_out.bad_header;
    assign o_accepted_count = res_out.count;
    assign o_seq_done       = res_out.done;
    assign o_seq_failed     = res_out.failed;
    assign o_run_last       = res_out.last;

endmodule
